// ===== hdl/cbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared codes and fixed widths of the 2D convolution unit with border modes.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  typedef logic [1:0] op_code_t;
  localparam op_code_t OP_WR_PIXEL = 2'd0;
  localparam op_code_t OP_WR_COEF  = 2'd1;
  localparam op_code_t OP_COMPUTE  = 2'd2;

  typedef logic [1:0] border_mode_t;
  localparam border_mode_t BM_CONSTANT  = 2'd0;
  localparam border_mode_t BM_REPLICATE = 2'd1;
  localparam border_mode_t BM_REFLECT   = 2'd2;

  typedef logic [2:0] cfg_index_t;
  localparam cfg_index_t CFG_BORDER_MODE  = 3'd0;
  localparam cfg_index_t CFG_BORDER_VALUE = 3'd1;
  localparam cfg_index_t CFG_IMAGE_WIDTH  = 3'd2;
  localparam cfg_index_t CFG_IMAGE_HEIGHT = 3'd3;
  localparam cfg_index_t CFG_RADIUS_X     = 3'd4;
  localparam cfg_index_t CFG_RADIUS_Y     = 3'd5;

  localparam int CFG_DATA_W = 8;
  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = CH_W + 1 + COEF_W;

endpackage

`default_nettype wire

// ===== hdl/cbm_if.sv =====
// ----------------------------------------------------------------------------
// cbm_if
// Valid/ready channels of the convolution unit: request beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [6:0]         pos_x;
  logic [6:0]         pos_y;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic [7:0]         alpha_in;
  logic [2:0]         tap_col;
  logic [2:0]         tap_row;
  logic signed [15:0] coefficient;

  modport source (
    output valid, operation, pos_x, pos_y, red_in, green_in, blue_in, alpha_in,
           tap_col, tap_row, coefficient,
    input  ready
  );
  modport sink (
    input  valid, operation, pos_x, pos_y, red_in, green_in, blue_in, alpha_in,
           tap_col, tap_row, coefficient,
    output ready
  );
endinterface

interface cbm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;

  modport source (
    output valid, red_out, green_out, blue_out, alpha_out,
    input  ready
  );
  modport sink (
    input  valid, red_out, green_out, blue_out, alpha_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/cbm_ram.sv =====
// ----------------------------------------------------------------------------
// cbm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/conv2d_border_modes_unit.sv =====
// ----------------------------------------------------------------------------
// conv2d_border_modes_unit
// RGBA frame store and kernel store with a tap-serial convolution engine that
// handles taps outside the image by constant, replicate or reflect borders.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | operation, position, RGBA, tap, coefficient
//   out_ch   | out | valid/ready        | filtered RGBA
//   cfg      | in  | cfg_we (no ready)  | cfg_index, cfg_data
//
// A compute beat takes one kernel tap per cycle through the single frame-store
// read port, then drains the pipeline and rounds. The stores need no clearing
// after reset. A result waiting on out_ch does not block writes; a following
// compute holds in its last cycle until out_ch frees.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_border_modes_unit
  import cbm_pkg::*;
#(
  parameter int MAX_WIDTH      = 128,
  parameter int MAX_HEIGHT     = 128,
  parameter int MAX_RADIUS     = 3,
  parameter int COEF_FRAC_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cbm_in_if.sink                     in_ch,
  cbm_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire cfg_index_t            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int KDIM   = 2 * MAX_RADIUS + 1;
  localparam int KDEPTH = KDIM * KDIM;
  localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int FA_W   = (FDEPTH > 1) ? $clog2(FDEPTH) : 1;
  localparam int KA_W   = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int KC_W   = (KDIM > 1) ? $clog2(KDIM) : 1;
  localparam int X_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_W    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int CW     = $clog2(MAX_WIDTH + MAX_HEIGHT + 256) + 3;
  localparam int ACC_W  = PROD_W + $clog2(KDEPTH + 1) + 1;
  localparam int RND    = (COEF_FRAC_BITS > 0) ? (1 << (COEF_FRAC_BITS - 1)) : 0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state_r;

  border_mode_t    border_mode_r;
  logic [7:0]      border_value_r;
  logic [7:0]      image_width_r;
  logic [7:0]      image_height_r;
  logic [1:0]      radius_x_r;
  logic [1:0]      radius_y_r;

  logic [6:0]      px_r;
  logic [6:0]      py_r;
  logic [KC_W-1:0] ci_r;
  logic [KC_W-1:0] cj_r;

  logic            s1_v_r;
  logic            s1_border_r;
  logic [X_W-1:0]  s1_x_r;
  logic [Y_W-1:0]  s1_y_r;
  logic [KA_W-1:0] s1_kaddr_r;
  logic            s2_v_r;
  logic            s2_border_r;
  logic            s3_v_r;
  logic signed [PROD_W-1:0] prod_r [4];
  logic signed [ACC_W-1:0]  acc_r  [4];

  logic            out_valid_r;
  logic [7:0]      res_r [4];

  logic            in_acc;
  logic            is_compute;
  logic [1:0]      rx_eff;
  logic [1:0]      ry_eff;
  logic [KC_W-1:0] lim_x;
  logic [KC_W-1:0] lim_y;
  logic signed [CW-1:0] w_eff;
  logic signed [CW-1:0] h_eff;
  logic signed [CW-1:0] xi;
  logic signed [CW-1:0] yi;
  logic signed [CW-1:0] xf;
  logic signed [CW-1:0] yf;
  logic            in_image;
  logic            use_border;
  logic            last_tap;
  logic            pipe_busy;

  logic            fs_we;
  logic [FA_W-1:0] fs_waddr;
  logic [FA_W-1:0] fs_raddr;
  logic [PIX_W-1:0] fs_wdata;
  logic [PIX_W-1:0] fs_rdata;
  logic            ks_we;
  logic [KA_W-1:0] ks_waddr;
  logic [COEF_W-1:0] ks_rdata;
  logic [PIX_W-1:0] pix;
  logic signed [COEF_W-1:0] coef;
  logic [7:0]      res_nxt [4];

  function automatic logic signed [CW-1:0] fold_coord(
    input logic signed [CW-1:0] c,
    input logic signed [CW-1:0] n,
    input border_mode_t         mode
  );
    logic signed [CW-1:0] r;
    r = c;
    if (mode == BM_REFLECT) begin
      if (c < 0) begin
        r = -c - CW'(1);
      end else if (c >= n) begin
        r = (n <<< 1) - c - CW'(1);
      end
    end
    if (r < 0) begin
      r = '0;
    end else if (r > n - CW'(1)) begin
      r = n - CW'(1);
    end
    return r;
  endfunction

  function automatic logic [7:0] round_sat(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W:0] v;
    logic signed [ACC_W:0] q;
    logic [7:0]            r;
    v = (ACC_W+1)'(s) + (ACC_W+1)'(RND);
    q = v >>> COEF_FRAC_BITS;
    if (v < 0) begin
      r = 8'd0;
    end else if (q > (ACC_W+1)'(255)) begin
      r = 8'd255;
    end else begin
      r = q[7:0];
    end
    return r;
  endfunction

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign is_compute  = (in_ch.operation == OP_COMPUTE);

  assign rx_eff = (int'(radius_x_r) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius_x_r;
  assign ry_eff = (int'(radius_y_r) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius_y_r;
  assign lim_x  = KC_W'(int'(rx_eff) * 2);
  assign lim_y  = KC_W'(int'(ry_eff) * 2);

  always_comb begin
    w_eff = CW'(int'(image_width_r));
    if (image_width_r == 8'd0) begin
      w_eff = CW'(1);
    end else if (int'(image_width_r) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end
    h_eff = CW'(int'(image_height_r));
    if (image_height_r == 8'd0) begin
      h_eff = CW'(1);
    end else if (int'(image_height_r) > MAX_HEIGHT) begin
      h_eff = CW'(MAX_HEIGHT);
    end
  end

  assign xi = CW'(int'(px_r) + int'(ci_r) - int'(rx_eff));
  assign yi = CW'(int'(py_r) + int'(cj_r) - int'(ry_eff));
  assign xf = fold_coord(xi, w_eff, border_mode_r);
  assign yf = fold_coord(yi, h_eff, border_mode_r);
  assign in_image = (xi >= 0) && (xi < w_eff) && (yi >= 0) && (yi < h_eff);
  assign use_border = !in_image && (border_mode_r != BM_REPLICATE) &&
                      (border_mode_r != BM_REFLECT);
  assign last_tap  = (ci_r == lim_x) && (cj_r == lim_y);
  assign pipe_busy = s1_v_r || s2_v_r || s3_v_r;

  assign fs_we    = in_acc && (in_ch.operation == OP_WR_PIXEL) &&
                    (int'(in_ch.pos_x) < MAX_WIDTH) && (int'(in_ch.pos_y) < MAX_HEIGHT);
  assign fs_waddr = FA_W'(int'(in_ch.pos_y) * MAX_WIDTH + int'(in_ch.pos_x));
  assign fs_wdata = {in_ch.alpha_in, in_ch.blue_in, in_ch.green_in, in_ch.red_in};
  assign fs_raddr = FA_W'(int'(s1_y_r) * MAX_WIDTH + int'(s1_x_r));
  assign ks_we    = in_acc && (in_ch.operation == OP_WR_COEF) &&
                    (int'(in_ch.tap_col) < KDIM) && (int'(in_ch.tap_row) < KDIM);
  assign ks_waddr = KA_W'(int'(in_ch.tap_row) * KDIM + int'(in_ch.tap_col));

  cbm_ram #(.WIDTH(PIX_W), .DEPTH(FDEPTH)) u_frame_ram (
    .clk     (clk),
    .wr_en   (fs_we),
    .wr_addr (fs_waddr),
    .wr_data (fs_wdata),
    .rd_addr (fs_raddr),
    .rd_data (fs_rdata)
  );

  cbm_ram #(.WIDTH(COEF_W), .DEPTH(KDEPTH)) u_coef_ram (
    .clk     (clk),
    .wr_en   (ks_we),
    .wr_addr (ks_waddr),
    .wr_data (in_ch.coefficient),
    .rd_addr (s1_kaddr_r),
    .rd_data (ks_rdata)
  );

  assign pix  = s2_border_r ? {4{border_value_r}} : fs_rdata;
  assign coef = $signed(ks_rdata);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      res_nxt[k] = round_sat(acc_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      border_mode_r  <= BM_CONSTANT;
      border_value_r <= 8'd0;
      image_width_r  <= 8'd128;
      image_height_r <= 8'd128;
      radius_x_r     <= 2'd1;
      radius_y_r     <= 2'd1;
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      s3_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BORDER_MODE:  border_mode_r  <= cfg_data[1:0];
          CFG_BORDER_VALUE: border_value_r <= cfg_data;
          CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
          CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
          CFG_RADIUS_X:     radius_x_r     <= cfg_data[1:0];
          CFG_RADIUS_Y:     radius_y_r     <= cfg_data[1:0];
          default: ;
        endcase
      end

      s1_v_r <= (state_r == ST_RUN);
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;

      if ((state_r == ST_FINISH) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc && is_compute) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (last_tap) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!pipe_busy) begin
            state_r <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end

    if (in_acc && is_compute) begin
      px_r <= in_ch.pos_x;
      py_r <= in_ch.pos_y;
      ci_r <= '0;
      cj_r <= '0;
      for (int k = 0; k < 4; k++) begin
        acc_r[k] <= '0;
      end
    end else begin
      if (state_r == ST_RUN) begin
        if (ci_r == lim_x) begin
          ci_r <= '0;
          cj_r <= cj_r + KC_W'(1);
        end else begin
          ci_r <= ci_r + KC_W'(1);
        end
      end
      if (s3_v_r) begin
        for (int k = 0; k < 4; k++) begin
          acc_r[k] <= acc_r[k] + ACC_W'(prod_r[k]);
        end
      end
    end

    s1_border_r <= use_border;
    s1_x_r      <= X_W'(xf);
    s1_y_r      <= Y_W'(yf);
    s1_kaddr_r  <= KA_W'(int'(cj_r) * KDIM + int'(ci_r));
    s2_border_r <= s1_border_r;
    for (int k = 0; k < 4; k++) begin
      prod_r[k] <= PROD_W'($signed({1'b0, pix[k*CH_W +: CH_W]})) * PROD_W'(coef);
    end

    if ((state_r == ST_FINISH) && (!out_valid_r || out_ch.ready)) begin
      for (int k = 0; k < 4; k++) begin
        res_r[k] <= res_nxt[k];
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = res_r[0];
  assign out_ch.green_out = res_r[1];
  assign out_ch.blue_out  = res_r[2];
  assign out_ch.alpha_out = res_r[3];

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pipe_busy)
    else $error("tap pipeline busy while idle");

  a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_compute) |=> (state_r == ST_RUN))
    else $error("compute beat did not start the tap sequence");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside the finish step");

  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ((ci_r <= lim_x) && (cj_r <= lim_y)))
    else $error("tap counter beyond kernel size");

  a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> !pipe_busy)
    else $error("rounding started before accumulation ended");

endmodule

`default_nettype wire
